// ===== hw/rtl/rgbc_pkg.sv =====
// Shared types, widths, register indexes and helper functions of the RGB 5x5 convolution block.
// No dependencies; every other file of the block imports this package.
package rgbc_pkg;

   localparam int POS_W   = 7;
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int SUM_W   = 14;
   localparam int SHIFT_W = 3;
   localparam int BIAS_W  = 9;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 9;
   localparam int REQ_DW  = 40;
   localparam int RSP_DW  = 24;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_FILTER = 1'b1
   } op_type;

   localparam logic [CSR_AW-1:0] CSR_SCALE_SHIFT = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_OFFSET_BIAS = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_GRAY_MARKER = 2'd2;

   typedef struct packed {
      logic [SHIFT_W-1:0]       scale_shift;
      logic signed [BIAS_W-1:0] offset_bias;
      logic [CH_W-1:0]          gray_marker;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      scale_shift: 3'd3,
      offset_bias: 9'sd0,
      gray_marker: 8'd128
   };

   typedef enum logic [1:0] {
      WT_NEG   = 2'b00,
      WT_TWO   = 2'b01,
      WT_EIGHT = 2'b10
   } weight_type;

   function automatic weight_type tap_weight(input logic [2:0] col, input logic [2:0] row);
      weight_type w;
      if (col == 3'd2 && row == 3'd2) begin
         w = WT_EIGHT;
      end else if (col >= 3'd1 && col <= 3'd3 && row >= 3'd1 && row <= 3'd3) begin
         w = WT_TWO;
      end else begin
         w = WT_NEG;
      end
      return w;
   endfunction

   function automatic logic signed [SUM_W-1:0] weighted(input logic [CH_W-1:0] v,
                                                        input weight_type w);
      logic signed [SUM_W-1:0] e;
      logic signed [SUM_W-1:0] r;
      e = $signed(SUM_W'(v));
      unique case (w)
         WT_NEG:   r = -e;
         WT_TWO:   r = e <<< 1;
         WT_EIGHT: r = e <<< 3;
         default:  r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/rgbc_csr.sv =====
// Configuration registers of the RGB 5x5 convolution block: scale shift, bias and gray marker.
// Depends on rgbc_pkg for the register indexes and the cfg_type record.
module rgbc_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [rgbc_pkg::CSR_AW-1:0] csr_addr,
   input  logic [rgbc_pkg::CSR_DW-1:0] csr_wdata,
   output rgbc_pkg::cfg_type         cfg
);
   import rgbc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SCALE_SHIFT: cfg_in.scale_shift = csr_wdata[SHIFT_W-1:0];
            CSR_OFFSET_BIAS: cfg_in.offset_bias = $signed(csr_wdata[BIAS_W-1:0]);
            CSR_GRAY_MARKER: cfg_in.gray_marker = csr_wdata[CH_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/rgbc_frame_mem.sv =====
// Single-port frame memory holding one RGB pixel per entry, read data registered.
// Depends on rgbc_pkg for the pixel width.
module rgbc_frame_mem #(
   parameter int AW = 14
) (
   input  logic                       clock,
   input  logic                       mem_en,
   input  logic                       mem_we,
   input  logic [AW-1:0]              mem_addr,
   input  logic [rgbc_pkg::PIX_W-1:0] mem_wdata,
   output logic [rgbc_pkg::PIX_W-1:0] mem_rdata
);
   import rgbc_pkg::*;

   logic [PIX_W-1:0] mem [2**AW];
   logic [PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff <= mem[mem_addr];
         end
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ===== hw/rtl/rgbc_post.sv =====
// Post-processing of one channel sum: shift toward zero, add bias, clamp to 0..255.
// Depends on rgbc_pkg for widths and the cfg_type record.
module rgbc_post (
   input  logic signed [rgbc_pkg::SUM_W-1:0] sum,
   input  rgbc_pkg::cfg_type                 cfg,
   output logic [rgbc_pkg::CH_W-1:0]         chan
);
   import rgbc_pkg::*;

   logic                    neg;
   logic [SUM_W-1:0]        mag;
   logic [SUM_W-1:0]        shifted;
   logic signed [SUM_W:0]   scaled;
   logic signed [SUM_W+1:0] biased;

   always_comb begin
      neg     = sum[SUM_W-1];
      mag     = neg ? SUM_W'(-sum) : SUM_W'(sum);
      shifted = mag >> cfg.scale_shift;
      scaled  = neg ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
      biased  = (SUM_W+2)'(scaled) + (SUM_W+2)'(cfg.offset_bias);
      priority if (biased < 0) begin
         chan = '0;
      end else if (biased > (SUM_W+2)'(255)) begin
         chan = '1;
      end else begin
         chan = biased[CH_W-1:0];
      end
   end

endmodule

// ===== hw/rtl/rgb_convolve_5x5_wrap.sv =====
// Top level of the RGB 5x5 edge-enhance convolution block: sequencer, accumulators, output.
// Depends on rgbc_pkg, rgbc_csr, rgbc_frame_mem and rgbc_post.
//
// The block keeps one FRAME_W x FRAME_H RGB frame in a single-port memory. A transfer on the
// req_ channel with tuser = 0 stores the pixel at (pos_x, pos_y); one with tuser = 1 asks for
// the filtered pixel there and yields one transfer on the rsp_ channel. Positions are reduced
// modulo the frame size, one subtraction per cycle (no subtraction is needed when the frame is at
// least 128 wide and high).
// The block takes one item at a time: req_tready is high only while it is idle. A load passes
// through reduction and the memory write before the next item can be taken. A request goes
// through reduction, one center read, 25 neighbor reads, a drain, an output step and a return
// to idle; the single memory port, read once per cycle, paces the neighbor reads. A center
// pixel with any channel equal to the gray marker ends the request after the center read.
// The result sits in an output register; a new item is accepted while it waits, and only the
// next result waits for rsp_tready.
// Reset clears the sequencer, the output valid and the configuration registers
// (shift 3, bias 0, gray marker 128). Frame contents are undefined until written.
module rgb_convolve_5x5_wrap #(
   parameter int FRAME_W = 128,
   parameter int FRAME_H = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // pos_x[6:0], pos_y[13:7], pixel_r[21:14], pixel_g[29:22], pixel_b[37:30], zero fill
   input  logic [rgbc_pkg::REQ_DW-1:0] req_tdata,
   // op
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_r[7:0], out_g[15:8], out_b[23:16]
   output logic [rgbc_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                        csr_we,
   input  logic [rgbc_pkg::CSR_AW-1:0] csr_addr,
   input  logic [rgbc_pkg::CSR_DW-1:0] csr_wdata
);
   import rgbc_pkg::*;

   localparam int XW  = $clog2(FRAME_W);
   localparam int YW  = $clog2(FRAME_H);
   localparam int XCW = (XW > POS_W) ? XW : POS_W;
   localparam int YCW = (YW > POS_W) ? YW : POS_W;
   localparam int AW  = XW + YW;
   localparam logic [XCW:0] W_C = (XCW+1)'(FRAME_W);
   localparam logic [YCW:0] H_C = (YCW+1)'(FRAME_H);
   localparam logic [XW:0]  W_X = (XW+1)'(FRAME_W);
   localparam logic [YW:0]  H_Y = (YW+1)'(FRAME_H);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_NORM   = 7'b0000010,
      ST_WRITE  = 7'b0000100,
      ST_CENTER = 7'b0001000,
      ST_READ   = 7'b0010000,
      ST_DRAIN  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [POS_W-1:0]        x_ff, x_in, y_ff, y_in;
   logic [PIX_W-1:0]        pix_ff, pix_in;
   logic [XW-1:0]           nx_ff, nx_in;
   logic [YW-1:0]           ny_ff, ny_in, ys_ff, ys_in;
   logic [2:0]              i_ff, i_in, j_ff, j_in;
   logic                    ctr_ff, ctr_in;
   logic                    dval_ff, dval_in;
   weight_type              wt_ff, wt_in;
   logic signed [SUM_W-1:0] acc_r_ff, acc_r_in, acc_g_ff, acc_g_in, acc_b_ff, acc_b_in;
   logic                    gray_ff, gray_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]       rsp_data_ff, rsp_data_in;

   cfg_type                 cfg;
   logic                    mem_en, mem_we;
   logic [AW-1:0]           mem_addr;
   logic [PIX_W-1:0]        mem_rdata;
   logic [CH_W-1:0]         post_r, post_g, post_b;

   logic [XCW-1:0]          x_ext;
   logic [YCW-1:0]          y_ext;
   logic                    x_big, y_big;
   logic [XW-1:0]           xr, xs, nx_next;
   logic [YW-1:0]           yr, ys, ny_next;
   logic                    gray_hit, out_free;

   rgbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rgbc_frame_mem #(.AW(AW)) u_mem (
      .clock     (clock),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (pix_ff),
      .mem_rdata (mem_rdata)
   );

   rgbc_post u_post_r (.sum(acc_r_ff), .cfg(cfg), .chan(post_r));
   rgbc_post u_post_g (.sum(acc_g_ff), .cfg(cfg), .chan(post_g));
   rgbc_post u_post_b (.sum(acc_b_ff), .cfg(cfg), .chan(post_b));

   always_comb begin
      x_ext   = XCW'(x_ff);
      y_ext   = YCW'(y_ff);
      x_big   = {1'b0, x_ext} >= W_C;
      y_big   = {1'b0, y_ext} >= H_C;
      xr      = x_ext[XW-1:0];
      yr      = y_ext[YW-1:0];
      xs      = (xr >= XW'(2)) ? xr - XW'(2) : XW'({1'b0, xr} + W_X - (XW+1)'(2));
      ys      = (yr >= YW'(2)) ? yr - YW'(2) : YW'({1'b0, yr} + H_Y - (YW+1)'(2));
      nx_next = (({1'b0, nx_ff} + (XW+1)'(1)) == W_X) ? '0 : nx_ff + XW'(1);
      ny_next = (({1'b0, ny_ff} + (YW+1)'(1)) == H_Y) ? '0 : ny_ff + YW'(1);
      gray_hit = ctr_ff && (mem_rdata[23:16] == cfg.gray_marker ||
                            mem_rdata[15:8] == cfg.gray_marker ||
                            mem_rdata[7:0] == cfg.gray_marker);
      out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      pix_in       = pix_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      ys_in        = ys_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      ctr_in       = ctr_ff;
      dval_in      = 1'b0;
      wt_in        = wt_ff;
      acc_r_in     = acc_r_ff;
      acc_g_in     = acc_g_ff;
      acc_b_in     = acc_b_ff;
      gray_in      = gray_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_en       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = {yr, xr};
      req_tready   = (state_ff == ST_IDLE);

      if (dval_ff && (state_ff == ST_READ || state_ff == ST_DRAIN)) begin
         acc_r_in = acc_r_ff + weighted(mem_rdata[23:16], wt_ff);
         acc_g_in = acc_g_ff + weighted(mem_rdata[15:8], wt_ff);
         acc_b_in = acc_b_ff + weighted(mem_rdata[7:0], wt_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = op_type'(req_tuser);
               x_in     = req_tdata[6:0];
               y_in     = req_tdata[13:7];
               pix_in   = {req_tdata[21:14], req_tdata[29:22], req_tdata[37:30]};
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (x_big) begin
               x_in = x_ff - W_C[POS_W-1:0];
            end
            if (y_big) begin
               y_in = y_ff - H_C[POS_W-1:0];
            end
            if (!x_big && !y_big) begin
               state_in = (op_ff == OP_LOAD) ? ST_WRITE : ST_CENTER;
            end
         end
         ST_WRITE: begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CENTER: begin
            mem_en   = 1'b1;
            nx_in    = xs;
            ny_in    = ys;
            ys_in    = ys;
            i_in     = '0;
            j_in     = '0;
            ctr_in   = 1'b1;
            gray_in  = 1'b0;
            acc_r_in = '0;
            acc_g_in = '0;
            acc_b_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            mem_en   = 1'b1;
            mem_addr = {ny_ff, nx_ff};
            ctr_in   = 1'b0;
            wt_in    = tap_weight(i_ff, j_ff);
            if (j_ff == 3'd4) begin
               j_in  = '0;
               ny_in = ys_ff;
               i_in  = i_ff + 3'd1;
               nx_in = nx_next;
            end else begin
               j_in  = j_ff + 3'd1;
               ny_in = ny_next;
            end
            priority if (gray_hit) begin
               gray_in  = 1'b1;
               state_in = ST_DONE;
            end else if (i_ff == 3'd4 && j_ff == 3'd4) begin
               dval_in  = 1'b1;
               state_in = ST_DRAIN;
            end else begin
               dval_in  = 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = gray_ff ? {cfg.gray_marker, cfg.gray_marker, cfg.gray_marker}
                                      : {post_b, post_g, post_r};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dval_ff      <= 1'b0;
         ctr_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dval_ff      <= dval_in;
         ctr_ff       <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      pix_ff      <= pix_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      ys_ff       <= ys_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      wt_ff       <= wt_in;
      acc_r_ff    <= acc_r_in;
      acc_g_ff    <= acc_g_in;
      acc_b_ff    <= acc_b_in;
      gray_ff     <= gray_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
